// ----- hw/rtl/swr_pkg.sv -----
`default_nettype none

package swr_pkg;

  localparam int unsigned SeqW = 32;

  typedef logic [SeqW-1:0] seq_t;

  localparam seq_t SeqZero = '0;
  localparam seq_t SeqOne  = seq_t'(1);

  typedef enum logic [1:0] {
    CMD_SEND  = 2'd0,
    CMD_TIMER = 2'd1,
    CMD_RECV  = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    seq_t pkt_seq;
    logic pkt_ack_flag;
    seq_t pkt_ack_num;
    logic pkt_has_data;
    logic pkt_bare_ack;
  } swr_in_t;

  typedef struct packed {
    seq_t stamp_seq;
    logic stamp_ack_flag;
    seq_t stamp_ack_num;
    logic resend;
    logic timer_start;
    logic timer_cancel;
    logic deliver_data;
    logic send_bare_ack;
  } swr_out_t;

  typedef struct packed {
    seq_t next_seq;
    seq_t expected_ack;
    logic outstanding_valid;
    seq_t outstanding_seq;
  } swr_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/swr_event.sv -----
`default_nettype none

module swr_event import swr_pkg::*; (
  input  wire swr_in_t    evt_i,
  input  wire swr_state_t state_i,
  output swr_state_t      state_o,
  output swr_out_t        res_o
);

  logic ack_hit;
  logic out_after;
  logic in_order;
  logic dup;

  // receive path compares, all in parallel
  assign ack_hit   = evt_i.pkt_ack_flag && state_i.outstanding_valid &&
                     ((evt_i.pkt_ack_num - SeqOne) == state_i.outstanding_seq);
  assign out_after = state_i.outstanding_valid && !ack_hit;
  assign in_order  = (evt_i.pkt_seq == state_i.expected_ack) ||
                     (state_i.expected_ack == SeqZero) ||
                     ((evt_i.pkt_seq - SeqOne) == state_i.expected_ack);
  assign dup       = ((evt_i.pkt_seq + SeqOne) == state_i.expected_ack) && !out_after;

  always_comb begin
    state_o = state_i;
    res_o   = '0;
    unique case (evt_i.cmd)
      CMD_SEND: begin
        res_o.stamp_seq  = state_i.next_seq;
        state_o.next_seq = state_i.next_seq + SeqOne;
        if (state_i.expected_ack != SeqZero) begin
          res_o.stamp_ack_flag = 1'b1;
          res_o.stamp_ack_num  = state_i.expected_ack;
        end
        if (!evt_i.pkt_bare_ack) begin
          state_o.outstanding_valid = 1'b1;
          state_o.outstanding_seq   = state_i.next_seq;
          res_o.timer_start         = 1'b1;
        end
      end
      CMD_TIMER: begin
        if (state_i.outstanding_valid) begin
          res_o.stamp_seq   = state_i.outstanding_seq;
          res_o.resend      = 1'b1;
          res_o.timer_start = 1'b1;
        end
      end
      CMD_RECV: begin
        state_o.outstanding_valid = out_after;
        res_o.timer_cancel        = ack_hit;
        if (in_order) begin
          state_o.expected_ack = evt_i.pkt_seq + SeqOne;
          res_o.deliver_data   = evt_i.pkt_has_data;
        end else if (dup) begin
          state_o.next_seq    = state_i.next_seq - SeqOne;
          res_o.send_bare_ack = !evt_i.pkt_has_data;
        end
      end
      default: begin
        state_o = state_i;
        res_o   = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/stop_and_wait_reliability.sv -----
// result path: each result is registered in the output register or, on a stall, the skid entry
// throughput: one transaction per cycle while the skid entry is free, set by the
//   combinational event logic and the state registers it updates; an output
//   register plus a skid entry keep the input side open while one result waits
// reset: asynchronous active low; sequence state, expected ack and the
//   outstanding packet are cleared and the output slots empty
`default_nettype none

module stop_and_wait_reliability import swr_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  // event channel
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire swr_in_t  in_data_i,
  // result channel
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output swr_out_t      out_data_o,
  // initial_sequence register write
  input  wire logic     cfg_we_i,
  input  wire seq_t     cfg_wdata_i
);

  swr_state_t state_q, state_d;
  swr_state_t evt_state;
  swr_out_t   res;

  swr_out_t   out_q, out_d;
  logic       out_valid_q, out_valid_d;
  swr_out_t   skid_q, skid_d;
  logic       skid_valid_q, skid_valid_d;

  logic       in_fire;
  logic       out_fire;

  // open as long as the skid entry is free
  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  // event logic works on the live state and the incoming transaction
  swr_event u_event (
    .evt_i   (in_data_i),
    .state_i (state_q),
    .state_o (evt_state),
    .res_o   (res)
  );

  always_comb begin
    state_d = state_q;
    if (in_fire) begin
      state_d = evt_state;
    end
    // a register write reloads the send counter; the user must write only while idle, the block does not enforce it
    if (cfg_we_i) begin
      state_d.next_seq = cfg_wdata_i;
    end
  end

  // output register with one skid entry behind it
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload holds need no reset
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- hw/rtl/swr_checker.sv -----
`default_nettype none

module swr_checker import swr_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire swr_out_t out_data_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // a new result only follows an accepted transaction
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("result appeared without an input transaction");

  a_ack_num_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.stamp_ack_flag |-> out_data_o.stamp_ack_num == SeqZero)
    else $error("ack number set without ack flag");

  a_resend_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.resend |->
      out_data_o.timer_start && !out_data_o.stamp_ack_flag && !out_data_o.timer_cancel)
    else $error("malformed resend result");

  a_recv_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.deliver_data || out_data_o.send_bare_ack) |->
      !(out_data_o.deliver_data && out_data_o.send_bare_ack) && !out_data_o.timer_start)
    else $error("deliver and bare ack mixed with send result");

endmodule

bind stop_and_wait_reliability swr_checker u_swr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
